// ----- hdl/klp_pkg.sv -----
package klp_pkg;

    localparam logic [1:0] OP_ADD_EDGE = 2'd0;
    localparam logic [1:0] OP_SUB_EDGE = 2'd1;
    localparam logic [1:0] OP_EXPIRY   = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [1:0] ADD_PENDING = 2'b01;
    localparam logic [1:0] SUB_PENDING = 2'b10;

    localparam logic [7:0]  TICK_SAT    = 8'd255;
    localparam logic [7:0]  LONG_RESET  = 8'd50;
    localparam logic [10:0] FLOOR_MA    = 11'd100;
    localparam logic [10:0] LOW_STEP    = 11'd50;
    localparam logic [10:0] HIGH_STEP   = 11'd100;
    localparam logic [10:0] LOW_LIMIT   = 11'd1000;
    localparam logic [10:0] HIGH_LIMIT  = 11'd2000;
    localparam int          HUNDRED_MAX = 20;

    typedef struct packed {
        logic [1:0] op;
        logic       add_key_level;
        logic       sub_key_level;
    } t_item;

    typedef struct packed {
        logic [1:0]  pending_edges;
        logic        tracking_add;
        logic [7:0]  held_ticks;
        logic        long_press_done;
        logic        range_mode;
        logic [10:0] setpoint;
    } t_state;

    typedef struct packed {
        logic [10:0] setpoint_ma;
        logic        high_range;
        logic        start_timer;
    } t_result;

    function automatic logic [10:0] step_up(input logic [10:0] sp, input logic rng);
        logic [11:0] sum;
        logic [10:0] step;
        logic [10:0] limit;
        logic [10:0] res;
        step  = rng ? HIGH_STEP : LOW_STEP;
        limit = rng ? HIGH_LIMIT : LOW_LIMIT;
        sum   = {1'b0, sp} + {1'b0, step};
        if (sp < FLOOR_MA) begin
            res = FLOOR_MA;
        end else if (sum > {1'b0, limit}) begin
            res = limit;
        end else begin
            res = sum[10:0];
        end
        return res;
    endfunction

    function automatic logic [10:0] step_down(input logic [10:0] sp, input logic rng);
        logic [10:0] step;
        logic [10:0] diff;
        logic [10:0] res;
        step = rng ? HIGH_STEP : LOW_STEP;
        diff = sp - step;
        if (sp <= FLOOR_MA) begin
            res = '0;
        end else if (sp > step) begin
            res = (diff < FLOOR_MA) ? FLOOR_MA : diff;
        end else begin
            res = '0;
        end
        return res;
    endfunction

    function automatic logic [10:0] round_hundreds(input logic [10:0] sp);
        logic [10:0] res;
        res = '0;
        for (int k = 1; k <= HUNDRED_MAX; k++) begin
            if (sp >= 11'(k * 100)) begin
                res = 11'(k * 100);
            end
        end
        return res;
    endfunction

endpackage

// ----- hdl/klp_in_stage.sv -----
module klp_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  klp_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_valid,
    output klp_pkg::t_item o_item
);

    logic           r_valid;
    logic           n_valid;
    klp_pkg::t_item r_item;

    assign o_in_stall = r_valid && !i_take;

    always_comb begin
        n_valid = r_valid;
        if (r_valid && i_take) begin
            n_valid = 1'b0;
        end
        if (i_in_valid && !o_in_stall) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_in_valid && !o_in_stall) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- hdl/klp_update.sv -----
module klp_update (
    input  klp_pkg::t_state  i_state,
    input  klp_pkg::t_item   i_item,
    input  logic [7:0]       i_long_ticks,
    output klp_pkg::t_state  o_state,
    output klp_pkg::t_result o_result
);

    klp_pkg::t_state s;
    logic            restart;
    logic            add_pressed;
    logic            sub_pressed;
    logic [1:0]      flags;

    always_comb begin
        s           = i_state;
        restart     = 1'b0;
        add_pressed = !i_item.add_key_level;
        sub_pressed = !i_item.sub_key_level;
        flags       = i_state.pending_edges;
        unique case (i_item.op)
            klp_pkg::OP_ADD_EDGE: begin
                s.pending_edges = s.pending_edges | klp_pkg::ADD_PENDING;
                restart         = 1'b1;
            end
            klp_pkg::OP_SUB_EDGE: begin
                s.pending_edges = s.pending_edges | klp_pkg::SUB_PENDING;
                restart         = 1'b1;
            end
            klp_pkg::OP_EXPIRY: begin
                s.pending_edges = '0;
                if (s.tracking_add) begin
                    if (add_pressed) begin
                        if (s.held_ticks < klp_pkg::TICK_SAT) begin
                            s.held_ticks = s.held_ticks + 8'd1;
                        end
                        if (!s.long_press_done && s.held_ticks >= i_long_ticks) begin
                            if (!s.range_mode) begin
                                s.range_mode = 1'b1;
                                s.setpoint   = klp_pkg::round_hundreds(s.setpoint);
                            end else begin
                                s.range_mode = 1'b0;
                                if (s.setpoint > klp_pkg::LOW_LIMIT) begin
                                    s.setpoint = klp_pkg::LOW_LIMIT;
                                end
                            end
                            s.long_press_done = 1'b1;
                        end
                        restart = 1'b1;
                    end else begin
                        if (!s.long_press_done) begin
                            s.setpoint = klp_pkg::step_up(s.setpoint, s.range_mode);
                        end
                        s.tracking_add    = 1'b0;
                        s.held_ticks      = '0;
                        s.long_press_done = 1'b0;
                    end
                end else if ((flags & klp_pkg::ADD_PENDING) != '0 && add_pressed) begin
                    s.tracking_add    = 1'b1;
                    s.held_ticks      = 8'd1;
                    s.long_press_done = 1'b0;
                    restart           = 1'b1;
                end
                if ((flags & klp_pkg::SUB_PENDING) != '0 && sub_pressed) begin
                    s.setpoint = klp_pkg::step_down(s.setpoint, s.range_mode);
                end
            end
            default: begin
                restart = 1'b0;
            end
        endcase
    end

    assign o_state              = s;
    assign o_result.setpoint_ma = s.setpoint;
    assign o_result.high_range  = s.range_mode;
    assign o_result.start_timer = restart;

endmodule

// ----- hdl/key_long_press_setpoint_control_core.sv -----
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_stall   i_op, i_add_key_level, i_sub_key_level
// out       output     o_out_valid / i_out_stall o_setpoint_ma, o_high_range, o_start_timer
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_data (long_press_ticks)
//
// One transaction per cycle sustained while the output is not stalled; a result is registered after acceptance.
// Latency comes from the input register and the result register; the update is one pass.
// Synchronous active-low reset clears state, setpoint and range and sets long_press_ticks to 50.
// A stall on the output holds the result register and backs up into the input register.
// Configuration is always ready.
module key_long_press_setpoint_control_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic        i_add_key_level,
    input  logic        i_sub_key_level,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [10:0] o_setpoint_ma,
    output logic        o_high_range,
    output logic        o_start_timer,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    klp_pkg::t_item   in_item;
    klp_pkg::t_item   s1_item;
    logic             s1_valid;
    logic             advance;
    klp_pkg::t_state  r_state;
    klp_pkg::t_state  n_state;
    klp_pkg::t_result n_result;
    klp_pkg::t_result r_out;
    logic             r_out_valid;
    logic [7:0]       r_long_ticks;

    assign in_item.op            = i_op;
    assign in_item.add_key_level = i_add_key_level;
    assign in_item.sub_key_level = i_sub_key_level;

    assign advance = !r_out_valid || !i_out_stall;

    klp_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_item     (in_item),
        .i_take     (advance),
        .o_valid    (s1_valid),
        .o_item     (s1_item)
    );

    klp_update u_update (
        .i_state      (r_state),
        .i_item       (s1_item),
        .i_long_ticks (r_long_ticks),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_state      <= '0;
            r_long_ticks <= klp_pkg::LONG_RESET;
        end else begin
            if (advance) begin
                r_out_valid <= s1_valid;
                if (s1_valid) begin
                    r_state <= n_state;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_long_ticks <= i_cfg_data;
            end
        end
        if (advance && s1_valid) begin
            r_out <= n_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_setpoint_ma = r_out.setpoint_ma;
    assign o_high_range  = r_out.high_range;
    assign o_start_timer = r_out.start_timer;

    a_low_range_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.range_mode |-> r_state.setpoint <= klp_pkg::LOW_LIMIT)
        else $error("setpoint above low range limit");

    a_high_range_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.range_mode |-> r_state.setpoint <= klp_pkg::HIGH_LIMIT)
        else $error("setpoint above high range limit");

    a_idle_tracking: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.tracking_add |-> (r_state.held_ticks == '0 && !r_state.long_press_done))
        else $error("tracking counters set without tracking");

    a_tracking_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.tracking_add |-> r_state.held_ticks != '0)
        else $error("tracking with zero held ticks");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(advance && s1_valid) |=> $stable(r_state))
        else $error("state changed without a transaction");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASE_ITEMS = 270;
    localparam int unsigned LONG_HOLD   = 150;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_op = klp_pkg::OP_ADD_EDGE;
    logic        i_add_key_level = 1'b1;
    logic        i_sub_key_level = 1'b1;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [10:0] o_setpoint_ma;
    logic        o_high_range;
    logic        o_start_timer;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data = '0;

    klp_pkg::t_item   key_events[$];
    klp_pkg::t_result pending_results[$];

    logic [7:0]  cfg_ticks = klp_pkg::LONG_RESET;
    logic [1:0]  pend_edges = '0;
    logic        add_tracked = 1'b0;
    logic [7:0]  held_count = '0;
    logic        long_done = 1'b0;
    logic        range_hi = 1'b0;
    logic [10:0] sp_ma = '0;

    int unsigned mismatches = 0;
    int unsigned events_queued = 0;
    int unsigned events_sent = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    logic        send_quiet = 1'b0;
    logic        recv_quiet = 1'b0;

    key_long_press_setpoint_control_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_add_key_level (i_add_key_level),
        .i_sub_key_level (i_sub_key_level),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_setpoint_ma   (o_setpoint_ma),
        .o_high_range    (o_high_range),
        .o_start_timer   (o_start_timer),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic klp_pkg::t_result predict_key_event(input klp_pkg::t_item ev);
        klp_pkg::t_result res;
        logic [1:0]       seen;
        int unsigned      lvl;
        int unsigned      lim;
        res.start_timer = 1'b0;
        case (ev.op)
            klp_pkg::OP_ADD_EDGE: begin
                pend_edges |= klp_pkg::ADD_PENDING;
                res.start_timer = 1'b1;
            end
            klp_pkg::OP_SUB_EDGE: begin
                pend_edges |= klp_pkg::SUB_PENDING;
                res.start_timer = 1'b1;
            end
            klp_pkg::OP_EXPIRY: begin
                seen = pend_edges;
                pend_edges = '0;
                if (add_tracked) begin
                    if (!ev.add_key_level) begin
                        if (held_count < klp_pkg::TICK_SAT) begin
                            held_count++;
                        end
                        if (!long_done && held_count >= cfg_ticks) begin
                            if (!range_hi) begin
                                range_hi = 1'b1;
                                sp_ma = (sp_ma / 100) * 100;
                            end else begin
                                range_hi = 1'b0;
                                if (sp_ma > klp_pkg::LOW_LIMIT) begin
                                    sp_ma = klp_pkg::LOW_LIMIT;
                                end
                            end
                            long_done = 1'b1;
                        end
                        res.start_timer = 1'b1;
                    end else begin
                        if (!long_done) begin
                            lvl = (sp_ma < klp_pkg::FLOOR_MA) ? klp_pkg::FLOOR_MA
                                : sp_ma + (range_hi ? klp_pkg::HIGH_STEP : klp_pkg::LOW_STEP);
                            lim = range_hi ? klp_pkg::HIGH_LIMIT : klp_pkg::LOW_LIMIT;
                            sp_ma = 11'((lvl > lim) ? lim : lvl);
                        end
                        add_tracked = 1'b0;
                        held_count = '0;
                        long_done = 1'b0;
                    end
                end else if ((seen & klp_pkg::ADD_PENDING) != 0 && !ev.add_key_level) begin
                    add_tracked = 1'b1;
                    held_count = 8'd1;
                    long_done = 1'b0;
                    res.start_timer = 1'b1;
                end
                if ((seen & klp_pkg::SUB_PENDING) != 0 && !ev.sub_key_level) begin
                    if (sp_ma <= klp_pkg::FLOOR_MA) begin
                        sp_ma = '0;
                    end else begin
                        lvl = sp_ma - (range_hi ? klp_pkg::HIGH_STEP : klp_pkg::LOW_STEP);
                        sp_ma = 11'((lvl < klp_pkg::FLOOR_MA) ? klp_pkg::FLOOR_MA : lvl);
                    end
                end
            end
            default: begin
            end
        endcase
        res.setpoint_ma = sp_ma;
        res.high_range = range_hi;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch on %0s at result %0d: got %0d, expected %0d",
                 field, results_seen, got, want);
        mismatches++;
    endtask

    task automatic push_event(input logic [1:0] op, input logic add_lvl, input logic sub_lvl);
        klp_pkg::t_item ev;
        ev.op = op;
        ev.add_key_level = add_lvl;
        ev.sub_key_level = sub_lvl;
        key_events.push_back(ev);
        if (op != klp_pkg::OP_RESERVED) begin
            events_queued++;
        end
    endtask

    task automatic add_press(input int unsigned held_ticks_extra);
        push_event(klp_pkg::OP_ADD_EDGE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        push_event(klp_pkg::OP_EXPIRY, 1'b0, 1'($urandom_range(0, 1)));
        repeat (held_ticks_extra) begin
            push_event(klp_pkg::OP_EXPIRY, 1'b0, 1'($urandom_range(0, 1)));
        end
        push_event(klp_pkg::OP_EXPIRY, 1'b1, 1'($urandom_range(0, 1)));
    endtask

    task automatic sub_press(input logic sub_lvl);
        push_event(klp_pkg::OP_SUB_EDGE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        push_event(klp_pkg::OP_EXPIRY, 1'b1, sub_lvl);
    endtask

    task automatic drain();
        while (key_events.size() != 0 || i_in_valid || pending_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        klp_pkg::t_item ev;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                pending_results.push_back(predict_key_event(
                    klp_pkg::t_item'({i_op, i_add_key_level, i_sub_key_level})));
                events_sent++;
                if (events_sent % 128 == 0) begin
                    send_quiet = ($urandom_range(0, 3) == 0);
                end
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (key_events.size() != 0) begin
                    ev = key_events.pop_front();
                    i_op <= ev.op;
                    i_add_key_level <= ev.add_key_level;
                    i_sub_key_level <= ev.sub_key_level;
                    i_in_valid <= 1'b1;
                    send_gap = send_quiet ? 0 : $urandom_range(0, 8);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                stall_left = recv_quiet ? 0 : $urandom_range(0, 8);
                if (results_seen % 100 == 0) begin
                    recv_quiet = ($urandom_range(0, 3) == 0);
                end
                if (results_seen == 400 || results_seen == 1100) begin
                    hold_left = LONG_HOLD;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        klp_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction", o_setpoint_ma, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_setpoint_ma !== want.setpoint_ma) begin
                    report_mismatch("setpoint_ma", o_setpoint_ma, want.setpoint_ma);
                end
                if (o_high_range !== want.high_range) begin
                    report_mismatch("high_range", o_high_range, want.high_range);
                end
                if (o_start_timer !== want.start_timer) begin
                    report_mismatch("start_timer", o_start_timer, want.start_timer);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d transactions outstanding", pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [7:0]  phase_cfg [6];
        int unsigned phase_end;
        int unsigned pick;
        phase_cfg[0] = klp_pkg::LONG_RESET;
        phase_cfg[1] = 8'd1;
        phase_cfg[2] = 8'd0;
        phase_cfg[3] = 8'd255;
        phase_cfg[4] = 8'($urandom_range(2, 30));
        phase_cfg[5] = 8'd7;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_event(klp_pkg::OP_RESERVED, 1'b0, 1'b0);
        sub_press(1'b0);
        add_press(0);
        add_press(1);
        sub_press(1'b0);
        sub_press(1'b0);
        push_event(klp_pkg::OP_ADD_EDGE, 1'b1, 1'b1);
        push_event(klp_pkg::OP_EXPIRY, 1'b1, 1'b1);
        push_event(klp_pkg::OP_RESERVED, 1'b1, 1'b1);
        push_event(klp_pkg::OP_ADD_EDGE, 1'b0, 1'b1);
        push_event(klp_pkg::OP_SUB_EDGE, 1'b1, 1'b0);
        push_event(klp_pkg::OP_EXPIRY, 1'b0, 1'b0);
        push_event(klp_pkg::OP_EXPIRY, 1'b1, 1'b0);
        push_event(klp_pkg::OP_EXPIRY, 1'b0, 1'b0);

        for (int ph = 0; ph < 6; ph++) begin
            if (ph != 0) begin
                drain();
                @(posedge i_clk);
                i_cfg_valid <= 1'b1;
                i_cfg_data <= phase_cfg[ph];
                do @(posedge i_clk); while (!o_cfg_ready);
                cfg_ticks = phase_cfg[ph];
                i_cfg_valid <= 1'b0;
            end
            phase_end = events_queued + PHASE_ITEMS;
            add_press(int'(cfg_ticks) + $urandom_range(0, 3));
            while (events_queued < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    add_press($urandom_range(0, 3));
                end else if (pick < 60) begin
                    sub_press(($urandom_range(0, 4) == 0));
                end else if (pick < 64 && cfg_ticks < 40) begin
                    add_press(int'(cfg_ticks) + $urandom_range(0, 3));
                end else if (pick < 72) begin
                    push_event(klp_pkg::OP_ADD_EDGE, 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
                    push_event(klp_pkg::OP_SUB_EDGE, 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
                    push_event(klp_pkg::OP_EXPIRY, 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
                end else begin
                    repeat ($urandom_range(1, 4)) begin
                        push_event(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)));
                    end
                end
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
